@@ hdl/cbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbcc_pkg: shared types and constants of the cluster box and cone classifier
// Payload structs, configuration layout and controller-to-datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package cbcc_pkg;

   // Coordinate width of points, centroids and extents
   localparam int COORD_BITS = 20;
   // Default bound on accumulated points per cluster
   localparam int MAX_CLUSTER_POINTS_DEF = 4096;

   // Configuration layout
   localparam int SIZE_W     = 20;
   localparam int RATIO_W    = 16;
   localparam int RATIO_FRAC = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int POINTS_W   = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X_MIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X_MAX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y_MIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MAX     = 3'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] centre_x;
      logic signed [COORD_BITS-1:0] centre_y;
      logic signed [COORD_BITS-1:0] centre_z;
      logic        [COORD_BITS-1:0] extent_x;
      logic        [COORD_BITS-1:0] extent_y;
      logic        [COORD_BITS-1:0] extent_z;
      logic        [POINTS_W-1:0]   points_seen;
      logic                         is_cone;
      logic                         too_many_points;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  cone_size_x_min;
      logic [SIZE_W-1:0]  cone_size_x_max;
      logic [SIZE_W-1:0]  cone_size_y_min;
      logic [SIZE_W-1:0]  cone_size_y_max;
      logic [RATIO_W-1:0] height_ratio_min;
      logic [RATIO_W-1:0] height_ratio_max;
   } cfg_type;

   // Ratio check index: bit 0 picks the max limit, bit 1 picks the x extent
   typedef struct packed {
      logic       accum;      // fold the accepted point into the accumulators
      logic       load;       // capture extents, size check and divider operands
      logic       ratio_mul;  // form one ratio limit times width product
      logic       ratio_cmp;  // compare height against the previous product
      logic [1:0] ratio_idx;
      logic       div_step;   // one quotient bit on all three axes
      logic       emit;       // load result register, clear accumulators
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/cbcc_csr.sv @@
// ----------------------------------------------------------------------------
// cbcc_csr: configuration registers
// Write-only register file for the size and ratio limits of the cone test.
// ----------------------------------------------------------------------------
`default_nettype none

module cbcc_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wr_en,
   input  wire  [cbcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [cbcc_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output cbcc_pkg::cfg_type                cfg
);
   import cbcc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cone_size_x_min  <= '0;
         cfg_ff.cone_size_x_max  <= '1;
         cfg_ff.cone_size_y_min  <= '0;
         cfg_ff.cone_size_y_max  <= '1;
         cfg_ff.height_ratio_min <= '0;
         cfg_ff.height_ratio_max <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE_X_MIN: cfg_ff.cone_size_x_min  <= csr_wr_data[SIZE_W-1:0];
            CSR_SIZE_X_MAX: cfg_ff.cone_size_x_max  <= csr_wr_data[SIZE_W-1:0];
            CSR_SIZE_Y_MIN: cfg_ff.cone_size_y_min  <= csr_wr_data[SIZE_W-1:0];
            CSR_SIZE_Y_MAX: cfg_ff.cone_size_y_max  <= csr_wr_data[SIZE_W-1:0];
            CSR_RATIO_MIN:  cfg_ff.height_ratio_min <= csr_wr_data[RATIO_W-1:0];
            CSR_RATIO_MAX:  cfg_ff.height_ratio_max <= csr_wr_data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/cbcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbcc_ctrl: controller of the cluster classifier
// Sequences accumulation, ratio checks, division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cbcc_ctrl #(
   parameter int MAX_CLUSTER_POINTS = cbcc_pkg::MAX_CLUSTER_POINTS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_last,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output cbcc_pkg::cmd_type  cmd
);
   import cbcc_pkg::*;

   localparam int CNT_W     = $clog2(MAX_CLUSTER_POINTS + 1);
   localparam int DIV_STEPS = COORD_BITS + CNT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);
   localparam logic [STEP_W-1:0] RATIO_LAST = STEP_W'(4);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_STEPS - 1);

   localparam logic [2:0] ST_ACCUM  = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_RATIO  = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_stall = (state_ff != ST_ACCUM);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.ratio_idx = step_ff[1:0];
      unique case (state_ff)
         ST_ACCUM: begin
            cmd.accum = accept;
            if (accept && req_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_RATIO;
         end
         ST_RATIO: begin
            cmd.ratio_mul = (step_ff != RATIO_LAST);
            cmd.ratio_cmp = (step_ff != '0);
            if (step_ff == RATIO_LAST) begin
               step_in  = '0;
               state_in = ST_DIVIDE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // Wait until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/cbcc_dpath.sv @@
// ----------------------------------------------------------------------------
// cbcc_dpath: datapath of the cluster classifier
// Accumulators, extents, shared ratio multiplier, bit-serial dividers and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbcc_dpath #(
   parameter int MAX_CLUSTER_POINTS = cbcc_pkg::MAX_CLUSTER_POINTS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  cbcc_pkg::req_type  req_data,
   input  cbcc_pkg::cfg_type  cfg,
   input  cbcc_pkg::cmd_type  cmd,
   output cbcc_pkg::rsp_type  rsp_data
);
   import cbcc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_CLUSTER_POINTS + 1);
   localparam int SUM_W  = COORD_BITS + CNT_W;
   localparam int PROD_W = RATIO_W + COORD_BITS;
   localparam int CMP_W  = (SIZE_W > COORD_BITS) ? SIZE_W : COORD_BITS;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLUSTER_POINTS);
   localparam logic signed [COORD_BITS-1:0] COORD_MAX_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] pt [3];
   logic signed [SUM_W-1:0]      sum_ff [3];
   logic signed [COORD_BITS-1:0] min_ff [3];
   logic signed [COORD_BITS-1:0] max_ff [3];
   logic [CNT_W-1:0]             cnt_ff;
   logic                         ovf_ff;

   logic [COORD_BITS-1:0]        ext_calc [3];
   logic [COORD_BITS-1:0]        ext_ff [3];
   logic                         cone_ff;
   logic                         size_ok;

   logic [PROD_W-1:0]            prod_ff;
   logic                         pidx_ff;
   logic [RATIO_W-1:0]           ratio_sel;
   logic [COORD_BITS-1:0]        width_sel;
   logic [PROD_W-1:0]            height_scaled;
   logic                         ratio_fail;

   logic [SUM_W-1:0]             quo_ff [3];
   logic [CNT_W-1:0]             rem_ff [3];
   logic                         neg_ff [3];
   logic [SUM_W-1:0]             quo_in [3];
   logic [CNT_W-1:0]             rem_in [3];
   logic [SUM_W-1:0]             mean [3];

   logic [CNT_W+POINTS_W-1:0]    cnt_wide;
   rsp_type                      rsp_ff;

   assign pt[0] = req_data.point_x;
   assign pt[1] = req_data.point_y;
   assign pt[2] = req_data.point_z;

   // Accumulators: drop extra points and flag overflow once the bound is reached
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
            min_ff[a] <= COORD_MAX_POS;
            max_ff[a] <= COORD_MIN_NEG;
         end
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.accum) begin
         if (cnt_ff == CNT_MAX) begin
            ovf_ff <= 1'b1;
         end else begin
            for (int a = 0; a < 3; a++) begin
               sum_ff[a] <= sum_ff[a] + SUM_W'(pt[a]);
               if (pt[a] < min_ff[a]) min_ff[a] <= pt[a];
               if (pt[a] > max_ff[a]) max_ff[a] <= pt[a];
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ext_calc[a] = max_ff[a] - min_ff[a];
      end
   end

   assign size_ok =
      (CMP_W'(ext_calc[0]) >= CMP_W'(cfg.cone_size_x_min)) &&
      (CMP_W'(ext_calc[0]) <= CMP_W'(cfg.cone_size_x_max)) &&
      (CMP_W'(ext_calc[1]) >= CMP_W'(cfg.cone_size_y_min)) &&
      (CMP_W'(ext_calc[1]) <= CMP_W'(cfg.cone_size_y_max));

   // Ratio checks as height * 256 against limit * width; a zero width makes
   // the product zero, so a zero height passes and any other height fails.
   assign ratio_sel     = cmd.ratio_idx[0] ? cfg.height_ratio_max : cfg.height_ratio_min;
   assign width_sel     = cmd.ratio_idx[1] ? ext_ff[0] : ext_ff[1];
   assign height_scaled = PROD_W'({ext_ff[2], {RATIO_FRAC{1'b0}}});
   assign ratio_fail    = pidx_ff ? (height_scaled > prod_ff)
                                  : (height_scaled < prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.ratio_mul) begin
         prod_ff <= PROD_W'(ratio_sel) * PROD_W'(width_sel);
         pidx_ff <= cmd.ratio_idx[0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cone_ff <= size_ok;
      end else if (cmd.ratio_cmp && ratio_fail) begin
         cone_ff <= 1'b0;
      end
   end

   // Restoring dividers on magnitudes, one quotient bit per step on each axis
   always_comb begin
      logic [CNT_W:0] trial;
      logic [CNT_W:0] diff;
      for (int a = 0; a < 3; a++) begin
         trial     = {rem_ff[a], quo_ff[a][SUM_W-1]};
         diff      = trial - {1'b0, cnt_ff};
         if (trial >= {1'b0, cnt_ff}) begin
            rem_in[a] = diff[CNT_W-1:0];
            quo_in[a] = {quo_ff[a][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[a] = trial[CNT_W-1:0];
            quo_in[a] = {quo_ff[a][SUM_W-2:0], 1'b0};
         end
         mean[a] = neg_ff[a] ? (~quo_ff[a] + 1'b1) : quo_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (cmd.load) begin
            ext_ff[a] <= ext_calc[a];
            neg_ff[a] <= sum_ff[a][SUM_W-1];
            quo_ff[a] <= sum_ff[a][SUM_W-1] ? (~sum_ff[a] + 1'b1) : sum_ff[a];
            rem_ff[a] <= '0;
         end else if (cmd.div_step) begin
            quo_ff[a] <= quo_in[a];
            rem_ff[a] <= rem_in[a];
         end
      end
   end

   assign cnt_wide = {{POINTS_W{1'b0}}, cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.centre_x        <= mean[0][COORD_BITS-1:0];
         rsp_ff.centre_y        <= mean[1][COORD_BITS-1:0];
         rsp_ff.centre_z        <= mean[2][COORD_BITS-1:0];
         rsp_ff.extent_x        <= ext_ff[0];
         rsp_ff.extent_y        <= ext_ff[1];
         rsp_ff.extent_z        <= ext_ff[2];
         rsp_ff.points_seen     <= cnt_wide[POINTS_W-1:0];
         rsp_ff.is_cone         <= cone_ff;
         rsp_ff.too_many_points <= ovf_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/cluster_box_cone_classifier.sv @@
// Throughput: a point without the last flag is taken every cycle while no cluster is closing.
// A point with the last flag closes the cluster: a load step, the ratio checks on
// the shared multiplier and the bit-serial division of each sum by the point count
// follow, then the result register loads, later while an earlier result still waits.
// The next cluster's first point is taken in the cycle after the result loads.
// Reset (synchronous, active high) clears accumulators, controller state and output
// valid, and sets the limits to their widest window.
// ----------------------------------------------------------------------------
// cluster_box_cone_classifier: cluster bounding box, centroid and cone test
// Accumulates per-axis sums, minima, maxima and a point count, then emits
// centroid, extents and the cone decision for each cluster.
// ----------------------------------------------------------------------------
`default_nettype none

module cluster_box_cone_classifier #(
   parameter int MAX_CLUSTER_POINTS = cbcc_pkg::MAX_CLUSTER_POINTS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // point input channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  cbcc_pkg::req_type                req_data,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output cbcc_pkg::rsp_type                rsp_data,
   // configuration write port
   input  wire                              csr_wr_en,
   input  wire  [cbcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [cbcc_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import cbcc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // Limits for the size and ratio checks; the user must write them only while idle, the block does not enforce it
   cbcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Controller: owns both handshakes. A transfer on the input channel folds
   // one point in; the flagged point starts the close-out sequence. The result
   // register frees the output side, so a waiting result only blocks the next
   // cluster's close-out, never its accumulation.
   cbcc_ctrl #(
      .MAX_CLUSTER_POINTS (MAX_CLUSTER_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_point),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: accumulators, ratio multiplier, dividers and result register
   cbcc_dpath #(
      .MAX_CLUSTER_POINTS (MAX_CLUSTER_POINTS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ dv/tb_cluster_box_cone_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_box_cone_classifier: self-checking bench for the cluster classifier
// Streams point clusters through the block under several limit settings; each
// box is checked against a typed row or a bench model of sums, box and cone test.
// ----------------------------------------------------------------------------

module tb_cluster_box_cone_classifier;
   import cbcc_pkg::*;

   localparam int MAX_POINTS       = MAX_CLUSTER_POINTS_DEF;
   localparam int COORD_MAX_POS    = 524287;
   localparam int COORD_MIN_NEG    = -524288;
   localparam int COORD_SPAN_FULL  = 1048575;
   localparam int LONG_HOLD_CYCLES = 300;
   // extra wait after the last box to let the close pass settle
   localparam int SETTLE_CYCLES    = 60;
   localparam int PHASE_POINTS     = 90;
   localparam int EXTREME_POINTS   = 64;
   // indexes past the last register, written only to see that they are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   cluster_box_cone_classifier #(
      .MAX_CLUSTER_POINTS(MAX_POINTS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Box model: running sums, bounding box, point count and the limit copy
   // --------------------------------------------------------------------------
   cfg_type limits;
   longint  box_sum [3];
   int      box_lo  [3];
   int      box_hi  [3];
   int      box_points;
   bit      box_overflow;

   // Boxes the block still owes us, oldest first
   rsp_type pending_boxes [$];

   // Bookkeeping, each written by one process only
   bit idling_on = 1'b0;
   int long_hold_requests = 0;
   int long_hold_served   = 0;
   int long_hold_left     = 0;
   int stall_burst_left   = 0;
   int points_sent        = 0;
   int clusters_closed    = 0;
   int overflow_clusters  = 0;
   int limit_settings     = 0;
   int boxes_checked      = 0;
   int cone_accepts       = 0;
   int mismatch_count     = 0;

   typedef struct {
      req_type pt;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows [$];

   function automatic void clear_box();
      for (int a = 0; a < 3; a++) begin
         box_sum[a] = 0;
         box_lo[a]  = COORD_MAX_POS;
         box_hi[a]  = COORD_MIN_NEG;
      end
      box_points   = 0;
      box_overflow = 1'b0;
   endfunction

   // Height over width against the Q8.8 window, as an exact cross-multiply.
   // Zero width passes only when the height is zero too.
   function automatic bit ratio_in_limits(input logic [COORD_BITS-1:0] h,
                                          input logic [COORD_BITS-1:0] d);
      logic [63:0] scaled_h;
      logic [63:0] lo_bound;
      logic [63:0] hi_bound;
      if (d == 0)
         return h == 0;
      scaled_h = 64'(h) << RATIO_FRAC;
      lo_bound = 64'(limits.height_ratio_min) * 64'(d);
      hi_bound = 64'(limits.height_ratio_max) * 64'(d);
      return (scaled_h >= lo_bound) && (scaled_h <= hi_bound);
   endfunction

   // Fold one accepted point in; on the last point build the box and clear.
   function automatic bit fold_point(input req_type pt, output rsp_type box);
      int                    coord [3];
      logic [COORD_BITS-1:0] centre [3];
      logic [COORD_BITS-1:0] span [3];
      longint                mean;
      int                    diff;
      box      = '0;
      coord[0] = pt.point_x;
      coord[1] = pt.point_y;
      coord[2] = pt.point_z;
      if (box_points >= MAX_POINTS) begin
         box_overflow = 1'b1;
      end else begin
         for (int a = 0; a < 3; a++) begin
            box_sum[a] += coord[a];
            if (coord[a] < box_lo[a]) box_lo[a] = coord[a];
            if (coord[a] > box_hi[a]) box_hi[a] = coord[a];
         end
         box_points++;
      end
      if (!pt.last_point)
         return 1'b0;
      for (int a = 0; a < 3; a++) begin
         // SV integer division truncates toward zero, as the block must
         mean      = box_sum[a] / longint'(box_points);
         centre[a] = mean[COORD_BITS-1:0];
         diff      = box_hi[a] - box_lo[a];
         span[a]   = diff[COORD_BITS-1:0];
      end
      box.centre_x        = centre[0];
      box.centre_y        = centre[1];
      box.centre_z        = centre[2];
      box.extent_x        = span[0];
      box.extent_y        = span[1];
      box.extent_z        = span[2];
      box.points_seen     = box_points[POINTS_W-1:0];
      box.too_many_points = box_overflow;
      box.is_cone = (span[0] >= limits.cone_size_x_min) && (span[0] <= limits.cone_size_x_max)
                 && (span[1] >= limits.cone_size_y_min) && (span[1] <= limits.cone_size_y_max)
                 && ratio_in_limits(span[2], span[1]) && ratio_in_limits(span[2], span[0]);
      clear_box();
      return 1'b1;
   endfunction

   function automatic void apply_limit(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SIZE_X_MIN: limits.cone_size_x_min  = value[SIZE_W-1:0];
         CSR_SIZE_X_MAX: limits.cone_size_x_max  = value[SIZE_W-1:0];
         CSR_SIZE_Y_MIN: limits.cone_size_y_min  = value[SIZE_W-1:0];
         CSR_SIZE_Y_MAX: limits.cone_size_y_max  = value[SIZE_W-1:0];
         CSR_RATIO_MIN:  limits.height_ratio_min = value[RATIO_W-1:0];
         CSR_RATIO_MAX:  limits.height_ratio_max = value[RATIO_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic req_type mk_point(input int x, input int y, input int z, input bit last);
      req_type p;
      p.point_x    = x[COORD_BITS-1:0];
      p.point_y    = y[COORD_BITS-1:0];
      p.point_z    = z[COORD_BITS-1:0];
      p.last_point = last;
      return p;
   endfunction

   function automatic rsp_type mk_result(input int cx, input int cy, input int cz,
                                         input int ex, input int ey, input int ez,
                                         input int n, input bit cone, input bit ovf);
      rsp_type r;
      r.centre_x        = cx[COORD_BITS-1:0];
      r.centre_y        = cy[COORD_BITS-1:0];
      r.centre_z        = cz[COORD_BITS-1:0];
      r.extent_x        = ex[COORD_BITS-1:0];
      r.extent_y        = ey[COORD_BITS-1:0];
      r.extent_z        = ez[COORD_BITS-1:0];
      r.points_seen     = n[POINTS_W-1:0];
      r.is_cone         = cone;
      r.too_many_points = ovf;
      return r;
   endfunction

   task automatic add_row(input req_type pt, input bit typed, input rsp_type want);
      stim_row_type row;
      row.pt    = pt;
      row.typed = typed;
      row.want  = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // --------------------------------------------------------------------------
   // Point side: offer one point, hold it until the transfer, then model it
   // --------------------------------------------------------------------------
   task automatic send_point(input req_type pt, input bit use_typed = 1'b0,
                             input rsp_type typed_box = '0);
      rsp_type box;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pt;
      do @(posedge clock); while (!(req_valid && !req_stall));
      points_sent++;
      if (fold_point(pt, box)) begin
         // a typed row checks the block on its own, the model still advances
         pending_boxes.insert(pending_boxes.size(), use_typed ? typed_box : box);
         clusters_closed++;
         if (box.too_many_points) overflow_clusters++;
      end
   endtask

   // Drop valid and wait for every owed box, then let the close pass settle
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_boxes.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Back-to-back writes keep the enable high; lower it once at the end
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      apply_limit(idx, value);
   endtask

   task automatic write_limits(input logic [CSR_DATA_W-1:0] x_min, input logic [CSR_DATA_W-1:0] x_max,
                               input logic [CSR_DATA_W-1:0] y_min, input logic [CSR_DATA_W-1:0] y_max,
                               input logic [CSR_DATA_W-1:0] r_min, input logic [CSR_DATA_W-1:0] r_max);
      write_csr(CSR_SIZE_X_MIN, x_min);
      write_csr(CSR_SIZE_X_MAX, x_max);
      write_csr(CSR_SPARE_A, CSR_DATA_W'($urandom));
      write_csr(CSR_SIZE_Y_MIN, y_min);
      write_csr(CSR_SIZE_Y_MAX, y_max);
      write_csr(CSR_RATIO_MIN, r_min);
      write_csr(CSR_SPARE_B, CSR_DATA_W'($urandom));
      write_csr(CSR_RATIO_MAX, r_max);
      csr_wr_en <= 1'b0;
      limit_settings++;
   endtask

   // One well-formed cluster: a random box, corners hit now and then,
   // sometimes full-range, sometimes flat on an axis or a cube.
   task automatic send_random_cluster();
      int n;
      int mode;
      int cube_span;
      bit corners;
      int span [3];
      int lo [3];
      int c [3];
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      mode      = $urandom_range(0, 7);
      cube_span = $urandom_range(0, 1500);
      corners   = 1'($urandom_range(0, 1));
      for (int a = 0; a < 3; a++) begin
         if (mode == 0)
            span[a] = $urandom_range(0, COORD_SPAN_FULL);
         else if (mode == 1)
            span[a] = cube_span;
         else if ($urandom_range(0, 5) == 0)
            span[a] = 0;
         else
            span[a] = $urandom_range(0, 1500);
         lo[a] = COORD_MIN_NEG + int'($urandom_range(0, COORD_SPAN_FULL - span[a]));
      end
      for (int i = 0; i < n; i++) begin
         for (int a = 0; a < 3; a++) begin
            if (corners && i == 0)
               c[a] = lo[a];
            else if (corners && i == 1)
               c[a] = lo[a] + span[a];
            else
               c[a] = lo[a] + int'($urandom_range(0, span[a]));
         end
         send_point(mk_point(c[0], c[1], c[2], i == n - 1));
      end
   endtask

   // --------------------------------------------------------------------------
   // Result side: check each transfer, then pick next cycle's stall
   // --------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("[%0t] mismatch on box %0d, %s: got %0d, want %0d",
                  $time, boxes_checked, what, got, want);
   endtask

   task automatic compare_box(input rsp_type got, input rsp_type want);
      if (got.centre_x !== want.centre_x) report_mismatch("centre_x", got.centre_x, want.centre_x);
      if (got.centre_y !== want.centre_y) report_mismatch("centre_y", got.centre_y, want.centre_y);
      if (got.centre_z !== want.centre_z) report_mismatch("centre_z", got.centre_z, want.centre_z);
      if (got.extent_x !== want.extent_x) report_mismatch("extent_x", got.extent_x, want.extent_x);
      if (got.extent_y !== want.extent_y) report_mismatch("extent_y", got.extent_y, want.extent_y);
      if (got.extent_z !== want.extent_z) report_mismatch("extent_z", got.extent_z, want.extent_z);
      if (got.points_seen !== want.points_seen)
         report_mismatch("points_seen", got.points_seen, want.points_seen);
      if (got.is_cone !== want.is_cone) report_mismatch("is_cone", got.is_cone, want.is_cone);
      if (got.too_many_points !== want.too_many_points)
         report_mismatch("too_many_points", got.too_many_points, want.too_many_points);
   endtask

   always @(posedge clock) begin : result_side
      rsp_type want;
      bit      hold_now;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_boxes.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_data.points_seen, 0);
            end else begin
               want = pending_boxes.pop_front();
               compare_box(rsp_data, want);
               if (want.is_cone) cone_accepts++;
            end
            boxes_checked++;
         end
         // a requested long hold wins over short bursts; count it down here
         if (long_hold_left > 0) begin
            long_hold_left--;
            hold_now = 1'b1;
         end else if (long_hold_served != long_hold_requests) begin
            long_hold_served++;
            long_hold_left = LONG_HOLD_CYCLES - 1;
            hold_now = 1'b1;
         end else if (stall_burst_left > 0) begin
            stall_burst_left--;
            hold_now = 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_burst_left = $urandom_range(0, 8);
            hold_now = 1'b1;
         end else begin
            hold_now = 1'b0;
         end
         rsp_stall <= hold_now;
      end
   end

   // --------------------------------------------------------------------------
   // Run sequence
   // --------------------------------------------------------------------------
   initial begin : stimulus
      int  phase_start;
      int  x_lo;
      int  y_lo;
      int  r_lo;
      bit  paused;
      // model starts from the reset limits and an empty box
      limits.cone_size_x_min  = '0;
      limits.cone_size_x_max  = '1;
      limits.cone_size_y_min  = '0;
      limits.cone_size_y_max  = '1;
      limits.height_ratio_min = '0;
      limits.height_ratio_max = '1;
      clear_box();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idling_on = 1'b1;

      // Directed clusters under reset limits. Typed rows are readable at a glance.
      // lone origin point: zero box, zero over zero ratio passes
      add_row(mk_point(0, 0, 0, 1), 1, mk_result(0, 0, 0, 0, 0, 0, 1, 1, 0));
      // lone point at the coordinate extremes
      add_row(mk_point(COORD_MAX_POS, COORD_MIN_NEG, COORD_MAX_POS, 1), 1,
              mk_result(COORD_MAX_POS, COORD_MIN_NEG, COORD_MAX_POS, 0, 0, 0, 1, 1, 0));
      // full-range box; sum of -1 over two truncates to zero
      add_row(mk_point(COORD_MIN_NEG, COORD_MIN_NEG, COORD_MIN_NEG, 0), 0, '0);
      add_row(mk_point(COORD_MAX_POS, COORD_MAX_POS, COORD_MAX_POS, 1), 1,
              mk_result(0, 0, 0, COORD_SPAN_FULL, COORD_SPAN_FULL, COORD_SPAN_FULL, 2, 1, 0));
      // height over zero width on both axes: rejected
      add_row(mk_point(0, 0, 0, 0), 0, '0);
      add_row(mk_point(0, 0, 5, 1), 1, mk_result(0, 0, 2, 0, 0, 5, 2, 0, 0));
      // negative means truncate toward zero
      add_row(mk_point(-3, -7, 0, 0), 0, '0);
      add_row(mk_point(0, 0, 0, 1), 1, mk_result(-1, -3, 0, 3, 7, 0, 2, 1, 0));
      // flat in y and z: zero over zero passes, zero over ten passes
      add_row(mk_point(10, 0, 0, 0), 0, '0);
      add_row(mk_point(20, 0, 0, 1), 1, mk_result(15, 0, 0, 10, 0, 0, 2, 1, 0));
      // zero width in x only, with height: rejected
      add_row(mk_point(0, 0, 0, 0), 0, '0);
      add_row(mk_point(0, 4, 4, 1), 1, mk_result(0, 2, 2, 0, 4, 4, 2, 0, 0));
      // alternating bit patterns on every coordinate bit
      add_row(mk_point(32'h55555, 32'hAAAAA, 32'h0F0F0, 0), 0, '0);
      add_row(mk_point(32'hAAAAA, 32'h55555, 32'hF0F0F, 0), 0, '0);
      add_row(mk_point(32'h00001, 32'hFFFFF, 32'h7FFFF, 1), 0, '0);
      // small mixed cluster left to the model
      add_row(mk_point(-100, 250, 900, 0), 0, '0);
      add_row(mk_point(40, -60, 1200, 0), 0, '0);
      add_row(mk_point(-20, 10, 1000, 1), 0, '0);

      foreach (directed_rows[i])
         send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
      drain_results(SETTLE_CYCLES);

      // Impossible window: every size check fails; ratio writes carry junk high bits
      write_limits(20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hF0000);
      repeat (8) send_random_cluster();
      drain_results(SETTLE_CYCLES);

      // Widest window, written out explicitly; run a long cluster with no idling
      write_limits(20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hA0000, 20'hFFFFF);
      idling_on = 1'b0;
      // points at the coordinate extremes: large positive and negative sums
      for (int i = 0; i < EXTREME_POINTS; i++)
         send_point(mk_point(COORD_MAX_POS, COORD_MIN_NEG, int'($urandom_range(0, COORD_SPAN_FULL))
                             + COORD_MIN_NEG, i == EXTREME_POINTS - 1));
      // the next cluster must start from a clean box
      repeat (3) send_random_cluster();
      drain_results(SETTLE_CYCLES);

      // Ratio pinned at exactly one: only cubes pass
      idling_on = 1'b1;
      write_limits(20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'd256, 20'd256);
      repeat (12) send_random_cluster();
      drain_results(SETTLE_CYCLES);

      // Random windows sized around the random boxes
      for (int phase = 0; phase < 6; phase++) begin
         x_lo = $urandom_range(0, 600);
         y_lo = $urandom_range(0, 600);
         r_lo = $urandom_range(0, 300);
         write_limits(CSR_DATA_W'(x_lo), CSR_DATA_W'(x_lo + $urandom_range(0, 1500)),
                      CSR_DATA_W'(y_lo), CSR_DATA_W'(y_lo + $urandom_range(0, 1500)),
                      CSR_DATA_W'(r_lo | ($urandom_range(0, 15) << RATIO_W)),
                      CSR_DATA_W'((r_lo + $urandom_range(0, 1200))
                                  | ($urandom_range(0, 15) << RATIO_W)));
         // one calm stretch mid-run, and none at all in the last part
         idling_on = (phase != 3) && (phase != 5);
         // hold the result side off long enough to back up the point side
         if (phase == 1) long_hold_requests++;
         phase_start = points_sent;
         paused = 1'b0;
         while (points_sent - phase_start < PHASE_POINTS) begin
            send_random_cluster();
            if (phase == 4 && !paused && points_sent - phase_start >= PHASE_POINTS / 2) begin
               drain_results(0);
               paused = 1'b1;
            end
         end
         drain_results(SETTLE_CYCLES);
      end

      $display("Run covered %0d points in %0d clusters over %0d limit settings, %0d past the bound.",
               points_sent, clusters_closed, limit_settings, overflow_clusters);
      $display("Checked %0d boxes, %0d accepted as cones, %0d field mismatches.",
               boxes_checked, cone_accepts, mismatch_count);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin : watchdog
      #6000000;
      $display("Timeout with %0d boxes still owed", pending_boxes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
